### design/sorted_interval_reservation_table_defines.svh
// Assertion macros for the interval reservation table checker.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef SORTED_INTERVAL_RESERVATION_TABLE_DEFINES_SVH
`define SORTED_INTERVAL_RESERVATION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/sirt_pkg.sv
// Shared types, codes and constants of the interval reservation table.
// Used by sirt_ctrl, sirt_mem, the top level and the checker; no dependencies.
package sirt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TW = 12;            // stored time width
  localparam int RW = 16;            // room tag width
  localparam int NW = 5;             // reported entry count width
  localparam logic [TW-1:0] TIME_MAX = 12'd2399;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EARLY   = 3'd1,
    ST_LATE    = 3'd2,
    ST_ORDER   = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_MISSING = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [TW-1:0] start_tm;
    logic [TW-1:0] stop_tm;
    logic [RW-1:0] room;
  } entry_t;

  typedef struct packed {
    status_t       status;
    logic [TW-1:0] found_end;
    logic [RW-1:0] found_room;
    logic [NW-1:0] entry_count;
  } res_t;

  function automatic status_t range_code(input logic signed [12:0] t);
    status_t code;
    if (t < 13'sd0) begin
      code = ST_EARLY;
    end else if (t > $signed({1'b0, TIME_MAX})) begin
      code = ST_LATE;
    end else begin
      code = ST_OK;
    end
    return code;
  endfunction

endpackage

### design/sirt_mem.sv
// Entry memory of the reservation table: one write port, one read port,
// read data registered. Uses sirt_pkg::entry_t.
module sirt_mem #(
  parameter int DEPTH = sirt_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(sirt_pkg::CAPACITY_DEF)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  sirt_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output sirt_pkg::entry_t rd_data
);

  sirt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/sirt_ctrl.sv
// Request sequencer: checks a request, walks the entry memory one entry per
// cycle for overlap or lookup, then shifts entries to insert or close a gap.
// Depends on sirt_pkg; drives sirt_mem.
module sirt_ctrl #(
  parameter int CAPACITY = sirt_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(sirt_pkg::CAPACITY_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req,
  input  logic signed [12:0]   in_begin,
  input  logic signed [12:0]   in_end,
  input  logic [15:0]          in_room,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sirt_pkg::res_t       res,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output sirt_pkg::entry_t     mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  sirt_pkg::entry_t     mem_rd_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  sirt_pkg::state_t state, state_next;
  sirt_pkg::req_t   op, op_next;
  logic [sirt_pkg::TW-1:0] bt, bt_next, et, et_next;
  logic [sirt_pkg::RW-1:0] room, room_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic          chk_vld, chk_vld_next;
  logic [AW-1:0] chk_idx, chk_idx_next;
  sirt_pkg::status_t rstat, rstat_next;
  logic [sirt_pkg::TW-1:0] rend, rend_next;
  logic [sirt_pkg::RW-1:0] rroom, rroom_next;

  logic              in_fire;
  logic              acc_go;
  sirt_pkg::status_t acc_stat;
  sirt_pkg::status_t b_code, e_code;
  logic              overlap, match, hit, scan_end, up_place, is_full;
  logic [CW-1:0]     up_dec;

  assign in_ready  = (state == sirt_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state == sirt_pkg::S_FINISH);

  assign b_code = sirt_pkg::range_code(in_begin);
  assign e_code = sirt_pkg::range_code(in_end);

  assign overlap  = !((mem_rd_data.stop_tm <= bt) || (mem_rd_data.start_tm >= et));
  assign match    = (mem_rd_data.start_tm == bt);
  assign hit      = chk_vld && ((op == sirt_pkg::REQ_INSERT) ? overlap : match);
  assign scan_end = (idx == count);
  assign up_dec   = idx - CW'(1);
  assign up_place = chk_vld ? !(mem_rd_data.start_tm > bt) : (pos == '0);
  assign is_full  = (count == CW'(CAPACITY));

  // Checks that need no table access.
  always_comb begin
    acc_go   = 1'b0;
    acc_stat = sirt_pkg::ST_OK;
    unique case (in_req)
      sirt_pkg::REQ_INSERT: begin
        priority if (b_code != sirt_pkg::ST_OK) begin
          acc_stat = b_code;
        end else if (e_code != sirt_pkg::ST_OK) begin
          acc_stat = e_code;
        end else if (in_begin >= in_end) begin
          acc_stat = sirt_pkg::ST_ORDER;
        end else begin
          acc_go = 1'b1;
        end
      end
      sirt_pkg::REQ_REMOVE, sirt_pkg::REQ_FIND: begin
        priority if (b_code != sirt_pkg::ST_OK) begin
          acc_stat = b_code;
        end else if (count == '0) begin
          acc_stat = sirt_pkg::ST_EMPTY;
        end else begin
          acc_go = 1'b1;
        end
      end
      default: begin
        acc_stat = sirt_pkg::ST_MISSING;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sirt_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = acc_go ? sirt_pkg::S_SCAN : sirt_pkg::S_FINISH;
        end
      end
      sirt_pkg::S_SCAN: begin
        if (hit) begin
          state_next = (op == sirt_pkg::REQ_REMOVE) ? sirt_pkg::S_SHIFT_DN
                                                    : sirt_pkg::S_FINISH;
        end else if (scan_end) begin
          state_next = (op == sirt_pkg::REQ_INSERT && !is_full) ? sirt_pkg::S_SHIFT_UP
                                                                : sirt_pkg::S_FINISH;
        end
      end
      sirt_pkg::S_SHIFT_UP: begin
        if (up_place) begin
          state_next = sirt_pkg::S_FINISH;
        end
      end
      sirt_pkg::S_SHIFT_DN: begin
        if (scan_end && !chk_vld) begin
          state_next = sirt_pkg::S_FINISH;
        end
      end
      sirt_pkg::S_FINISH: begin
        if (res_ready) begin
          state_next = sirt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sirt_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and memory controls. Reads run ahead of writes in the walk
  // direction, so a read never sees an entry rewritten by the same request;
  // the finish cycle keeps the last write clear of the next request's reads.
  always_comb begin
    op_next      = op;
    bt_next      = bt;
    et_next      = et;
    room_next    = room;
    count_next   = count;
    idx_next     = idx;
    pos_next     = pos;
    chk_vld_next = chk_vld;
    chk_idx_next = chk_idx;
    rstat_next   = rstat;
    rend_next    = rend;
    rroom_next   = rroom;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = pos[AW-1:0];
    mem_wr_data  = mem_rd_data;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = idx[AW-1:0];
    unique case (state)
      sirt_pkg::S_IDLE: begin
        if (in_fire) begin
          op_next      = sirt_pkg::req_t'(in_req);
          bt_next      = in_begin[sirt_pkg::TW-1:0];
          et_next      = in_end[sirt_pkg::TW-1:0];
          room_next    = in_room;
          idx_next     = '0;
          chk_vld_next = 1'b0;
          rstat_next   = acc_stat;
          rend_next    = '0;
          rroom_next   = '0;
        end
      end
      sirt_pkg::S_SCAN: begin
        if (!scan_end) begin
          mem_rd_en    = 1'b1;
          idx_next     = idx + CW'(1);
          chk_vld_next = 1'b1;
          chk_idx_next = idx[AW-1:0];
        end else begin
          chk_vld_next = 1'b0;
        end
        if (hit) begin
          if (op == sirt_pkg::REQ_INSERT) begin
            rstat_next = sirt_pkg::ST_OVERLAP;
          end else if (op == sirt_pkg::REQ_FIND) begin
            rend_next  = mem_rd_data.stop_tm;
            rroom_next = mem_rd_data.room;
          end else begin
            // close the gap: copy down from the entry after the hit
            pos_next     = CW'(chk_idx);
            idx_next     = CW'(chk_idx) + CW'(1);
            chk_vld_next = 1'b0;
          end
        end else if (scan_end) begin
          if (op != sirt_pkg::REQ_INSERT) begin
            rstat_next = sirt_pkg::ST_MISSING;
          end else if (is_full) begin
            rstat_next = sirt_pkg::ST_FULL;
          end else begin
            pos_next     = count;
            idx_next     = count;
            chk_vld_next = 1'b0;
          end
        end
      end
      sirt_pkg::S_SHIFT_UP: begin
        mem_rd_addr = up_dec[AW-1:0];
        if (idx != '0) begin
          mem_rd_en    = 1'b1;
          idx_next     = up_dec;
          chk_vld_next = 1'b1;
        end else begin
          chk_vld_next = 1'b0;
        end
        if (up_place) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = '{start_tm: bt, stop_tm: et, room: room};
          count_next  = count + CW'(1);
        end else if (chk_vld) begin
          // later begin: move it up one slot
          mem_wr_en = 1'b1;
          pos_next  = pos - CW'(1);
        end
      end
      sirt_pkg::S_SHIFT_DN: begin
        if (!scan_end) begin
          mem_rd_en    = 1'b1;
          idx_next     = idx + CW'(1);
          chk_vld_next = 1'b1;
        end else begin
          chk_vld_next = 1'b0;
        end
        if (chk_vld) begin
          mem_wr_en = 1'b1;
          pos_next  = pos + CW'(1);
        end else if (scan_end) begin
          count_next = count - CW'(1);
        end
      end
      sirt_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sirt_pkg::S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      chk_vld <= chk_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    bt      <= bt_next;
    et      <= et_next;
    room    <= room_next;
    idx     <= idx_next;
    pos     <= pos_next;
    chk_idx <= chk_idx_next;
    rstat   <= rstat_next;
    rend    <= rend_next;
    rroom   <= rroom_next;
  end

  assign res = '{status:      rstat,
                 found_end:   rend,
                 found_room:  rroom,
                 entry_count: sirt_pkg::NW'(count)};

endmodule

### design/sorted_interval_reservation_table.sv
// Sorted interval reservation table, one request at a time over a two-port entry memory.
// A request rejected on its fields goes straight to the result word. Find scans the stored
// entries; insert scans them and, with no overlap and room left, shifts later entries up;
// remove scans them and, on a hit, shifts the entries after it down. The next request is
// taken the cycle after the result word loads; the memory walk sets each request's duration.
// Reset (rst, synchronous) empties the table: the count clears, entry memory is left as is.
module sorted_interval_reservation_table #(
  parameter int CAPACITY = sirt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic signed [12:0]  begin_time,
  input  logic signed [12:0]  end_time,
  input  logic [15:0]         room_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [11:0]         found_end,
  output logic [15:0]         found_room,
  output logic [4:0]          entry_count
);

  localparam int AW = $clog2(CAPACITY);

  logic             res_valid, res_ready;
  sirt_pkg::res_t   res, out_word;
  logic             mem_wr_en, mem_rd_en;
  logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
  sirt_pkg::entry_t mem_wr_data, mem_rd_data;

  sirt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (req_type),
    .in_begin    (begin_time),
    .in_end      (end_time),
    .in_room     (room_number),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  sirt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output word register: load when empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign status      = out_word.status;
  assign found_end   = out_word.found_end;
  assign found_room  = out_word.found_room;
  assign entry_count = out_word.entry_count;

endmodule

### design/sirt_check.sv
// Port-level checker for the reservation table, bound to the top level.
// Depends on sirt_pkg and sorted_interval_reservation_table_defines.svh.
`include "sorted_interval_reservation_table_defines.svh"

module sirt_check #(
  parameter int CAPACITY = sirt_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [11:0] found_end,
  input logic [15:0] found_room,
  input logic [4:0]  entry_count
);

  logic        stall;
  logic        failed;
  logic        found_clear;
  logic        end_ok;
  logic        cnt_ok;
  logic [35:0] out_bits;

  assign stall       = out_valid && !out_ready;
  assign failed      = out_valid && (status != sirt_pkg::ST_OK);
  assign found_clear = (found_end == '0) && (found_room == '0);
  assign end_ok      = (found_end <= sirt_pkg::TIME_MAX);
  assign cnt_ok      = (CAPACITY >= 32) || (int'(entry_count) <= CAPACITY);
  assign out_bits    = {status, found_end, found_room, entry_count};

  // a stalled result word holds
  `SIRT_ASSERT_NEXT(a_out_hold, clk, rst, stall, out_valid && $stable(out_bits), "stalled word moved")

  // only a successful find reports end and room
  `SIRT_ASSERT_NOW(a_found_zero, clk, rst, failed, found_clear, "found fields set on failure")

  `SIRT_ASSERT_NOW(a_found_range, clk, rst, out_valid, end_ok, "found end beyond the day")

  `SIRT_ASSERT_NOW(a_count_cap, clk, rst, out_valid, cnt_ok, "entry count above capacity")

endmodule

bind sorted_interval_reservation_table sirt_check #(
  .CAPACITY (CAPACITY)
) u_sirt_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .found_end   (found_end),
  .found_room  (found_room),
  .entry_count (entry_count)
);
